// ===== src/cmr_pkg.sv =====
// Shared types and constants for the CAN multi-frame reassembler.
// No dependencies; imported by the top level and the testbench.
package cmr_pkg;

   localparam int SESSIONS_DEF   = 8;
   localparam int MAX_PACKET_DEF = 64;
   localparam int KEY_W          = 24;
   localparam int LEN_W          = 7;

   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_NO_SLOT = 3'd2;
   localparam logic [2:0] ST_OUT_SEQ = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;
   localparam logic [2:0] ST_OVERRUN = 3'd5;
   localparam logic [2:0] ST_DELIVER = 3'd6;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_WRITE,
      S_DLV,
      S_SHORT,
      S_STATUS
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] received;
      logic [LEN_W-1:0] total;
   } meta_type;

   typedef struct packed {
      logic             strobe;
      logic             kind;
      logic [2:0]       status;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] packet_length;
      logic             last;
      logic             from_mem;
   } rsp_type;

endpackage

// ===== src/can_multiframe_reassembler.sv =====
// CAN multi-frame reassembler, top level.
// Depends on cmr_pkg and cmr_byte_ram.
//
// One frame is a transfer on start while busy is low. Each frame yields one
// status result, or a delivered packet one byte per cycle on consecutive
// cycles, marked by rsp_strobe; the receiver cannot stall, so every result
// is shown for exactly one cycle. The session lookup reads the metadata
// memory one entry per cycle, payload bytes are stored one per cycle through
// the single byte write port, and delivered bytes are read one per cycle
// through the single byte read port. The final byte leaves in the cycle in
// which busy drops. No clearing pass is needed.
module can_multiframe_reassembler
   import cmr_pkg::*;
#(
   parameter int SESSIONS   = SESSIONS_DEF,
   parameter int MAX_PACKET = MAX_PACKET_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [7:0]       req_dst_addr,
   input  logic [7:0]       req_src_addr,
   input  logic [7:0]       req_dev_type,
   input  logic [7:0]       req_frame_seq,
   input  logic [3:0]       req_frame_len,
   input  logic [63:0]      req_payload,
   output logic             rsp_strobe,
   output logic             rsp_kind,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_data_byte,
   output logic [LEN_W-1:0] rsp_packet_length,
   output logic             rsp_last
);
   localparam int SW    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int CW    = $clog2(SESSIONS + 1);
   localparam int DEPTH = SESSIONS * MAX_PACKET;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;

   // session metadata memory and valid flops
   meta_type meta_mem [SESSIONS];
   meta_type meta_rd_ff;
   logic     meta_we;
   logic [SW-1:0] meta_waddr;
   meta_type meta_wdata;
   logic [SESSIONS-1:0] valid_ff;

   // latched frame
   logic [KEY_W-1:0] key_ff;
   logic [7:0]       seq_ff;
   logic [3:0]       len_ff;
   logic [63:0]      pl_ff;

   // lookup results
   logic [CW-1:0]    scan_ff;
   logic             hit_ff, free_ok_ff;
   logic [SW-1:0]    hit_slot_ff, free_slot_ff;
   logic [LEN_W-1:0] hit_rx_ff, hit_tot_ff;

   logic [AW-1:0]    base_ff;
   logic [LEN_W-1:0] wofs_ff, idx_ff, tot_ff;
   logic             done_ff;
   logic [2:0]       stat_ff;

   rsp_type rsp_ff, rsp_in;

   // store ports
   logic          st_we;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [7:0]    st_wdata, st_rdata;

   // decision terms
   logic [SW-1:0]  chk_idx;
   logic           chk_hit;
   logic [CW-1:0]  chk_cnt;
   logic [7:0]     seq_m1;
   logic           seq_ok, overrun;
   logic [7:0]     sum;
   logic [15:0]    body;
   logic           short_pkt, too_long;
   logic [7:0]     cur_byte;
   logic           do_new, do_hit;

   cmr_byte_ram #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock  (clock),
      .wr_en  (st_we),
      .wr_addr(st_waddr),
      .wr_data(st_wdata),
      .rd_addr(st_raddr),
      .rd_data(st_rdata)
   );

   assign busy = (state_ff != S_IDLE);

   // lookup check uses the registered read, in the cycle after the read
   assign chk_cnt = scan_ff - CW'(1);
   assign chk_idx = chk_cnt[SW-1:0];
   assign chk_hit = valid_ff[chk_idx] && (meta_rd_ff.key == key_ff);

   assign seq_m1   = seq_ff - 8'd1;
   assign seq_ok   = (seq_ff != 8'd0) && ({seq_m1, 3'b000} == 11'(hit_rx_ff));
   assign sum      = 8'(hit_rx_ff) + 8'(len_ff);
   assign overrun  = (sum > 8'(hit_tot_ff)) || (sum > 8'(MAX_PACKET));
   assign body     = {pl_ff[23:16], pl_ff[31:24]};
   assign short_pkt = (body <= 16'd4);
   assign too_long  = (body > 16'(MAX_PACKET - 4));
   assign cur_byte  = pl_ff[{idx_ff[2:0], 3'b000} +: 8];

   assign do_hit = hit_ff && seq_ok && !overrun;
   assign do_new = !hit_ff && (len_ff > 4'd3) && !short_pkt && (seq_ff == 8'd1)
                   && !too_long && free_ok_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_frame_len == 4'd0) ? S_STATUS : S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff == CW'(SESSIONS)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (do_hit || do_new) begin
               state_in = S_WRITE;
            end else if (!hit_ff && (len_ff > 4'd3) && short_pkt) begin
               state_in = S_SHORT;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_WRITE: begin
            if (idx_ff == LEN_W'(len_ff - 4'd1)) begin
               state_in = done_ff ? S_DLV : S_STATUS;
            end
         end
         S_DLV: begin
            if (idx_ff == tot_ff - LEN_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_SHORT: begin
            if (idx_ff == LEN_W'(len_ff - 4'd1)) begin
               state_in = S_IDLE;
            end
         end
         S_STATUS: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      rsp_in     = '0;
      meta_we    = 1'b0;
      meta_waddr = hit_slot_ff;
      meta_wdata = '0;
      st_we      = 1'b0;
      st_waddr   = base_ff + AW'(wofs_ff) + AW'(idx_ff);
      st_wdata   = cur_byte;
      st_raddr   = base_ff + AW'(idx_ff);
      case (state_ff)
         S_DECIDE: begin
            if (do_hit) begin
               meta_we    = 1'b1;
               meta_waddr = hit_slot_ff;
               meta_wdata = '{key: key_ff, received: LEN_W'(sum), total: hit_tot_ff};
            end else if (do_new) begin
               meta_we    = 1'b1;
               meta_waddr = free_slot_ff;
               meta_wdata = '{key: key_ff, received: LEN_W'(len_ff),
                              total: LEN_W'(body + 16'd4)};
            end
         end
         S_WRITE: st_we = 1'b1;
         S_DLV: begin
            rsp_in.strobe        = 1'b1;
            rsp_in.kind          = KIND_BYTE;
            rsp_in.status        = ST_DELIVER;
            rsp_in.packet_length = tot_ff;
            rsp_in.last          = (idx_ff == tot_ff - LEN_W'(1));
            rsp_in.from_mem      = 1'b1;
         end
         S_SHORT: begin
            rsp_in.strobe        = 1'b1;
            rsp_in.kind          = KIND_BYTE;
            rsp_in.status        = ST_DELIVER;
            rsp_in.data_byte     = cur_byte;
            rsp_in.packet_length = LEN_W'(len_ff);
            rsp_in.last          = (idx_ff == LEN_W'(len_ff - 4'd1));
         end
         S_STATUS: begin
            rsp_in.strobe = 1'b1;
            rsp_in.kind   = KIND_STATUS;
            rsp_in.status = stat_ff;
            rsp_in.last   = 1'b1;
         end
         default: ;
      endcase
   end

   // metadata memory
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[scan_ff[SW-1:0]];
   end

   // control state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
         if (state_ff == S_DECIDE && do_new) begin
            valid_ff[free_slot_ff] <= 1'b1;
         end
         if (state_ff == S_DECIDE && do_hit && (sum == 8'(hit_tot_ff))) begin
            valid_ff[hit_slot_ff] <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            key_ff     <= {req_dev_type, req_src_addr, req_dst_addr};
            seq_ff     <= req_frame_seq;
            len_ff     <= (req_frame_len > 4'd8) ? 4'd8 : req_frame_len;
            pl_ff      <= req_payload;
            stat_ff    <= ST_EMPTY;
            scan_ff    <= '0;
            hit_ff     <= 1'b0;
            free_ok_ff <= 1'b0;
            idx_ff     <= '0;
         end
         S_SCAN: begin
            if (scan_ff != CW'(SESSIONS)) begin
               scan_ff <= scan_ff + CW'(1);
            end
            if (scan_ff != '0) begin
               if (chk_hit) begin
                  hit_ff      <= 1'b1;
                  hit_slot_ff <= chk_idx;
                  hit_rx_ff   <= meta_rd_ff.received;
                  hit_tot_ff  <= meta_rd_ff.total;
               end
               if (!valid_ff[chk_idx] && !free_ok_ff) begin
                  free_ok_ff   <= 1'b1;
                  free_slot_ff <= chk_idx;
               end
            end
         end
         S_DECIDE: begin
            idx_ff  <= '0;
            stat_ff <= ST_STORED;
            if (hit_ff) begin
               base_ff <= AW'(hit_slot_ff) * AW'(MAX_PACKET);
               wofs_ff <= hit_rx_ff;
               tot_ff  <= hit_tot_ff;
               done_ff <= (sum == 8'(hit_tot_ff));
               if (!seq_ok) begin
                  stat_ff <= ST_OUT_SEQ;
               end else if (overrun) begin
                  stat_ff <= ST_OVERRUN;
               end
            end else begin
               base_ff <= AW'(free_slot_ff) * AW'(MAX_PACKET);
               wofs_ff <= '0;
               done_ff <= 1'b0;
               if (len_ff <= 4'd3) begin
                  stat_ff <= ST_IGNORED;
               end else if (!do_new) begin
                  stat_ff <= ST_NO_SLOT;
               end
            end
         end
         S_WRITE: begin
            idx_ff <= (idx_ff == LEN_W'(len_ff - 4'd1)) ? '0 : idx_ff + LEN_W'(1);
         end
         S_DLV, S_SHORT: idx_ff <= idx_ff + LEN_W'(1);
         default: ;
      endcase
   end

   assign rsp_strobe        = rsp_ff.strobe;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_status        = rsp_ff.status;
   assign rsp_data_byte     = rsp_ff.from_mem ? st_rdata : rsp_ff.data_byte;
   assign rsp_packet_length = rsp_ff.packet_length;
   assign rsp_last          = rsp_ff.last;
endmodule

// ===== src/cmr_byte_ram.sv =====
// Packet byte store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module cmr_byte_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for can_multiframe_reassembler.
// Depends on cmr_pkg and the block's RTL; frames in, packet bytes and status checked out.
`timescale 1ns / 100ps

module tb;
   import cmr_pkg::*;

   localparam int SESS = SESSIONS_DEF;
   localparam int MAXP = MAX_PACKET_DEF;
   localparam int RANDOM_FRAMES = 285;
   localparam int QUIET_TAIL = 40;      // no sender gaps over the last frames

   typedef struct packed {
      logic [7:0]  dst;
      logic [7:0]  src;
      logic [7:0]  dev;
      logic [7:0]  seq;
      logic [3:0]  len;
      logic [63:0] pl;
   } frame_t;

   typedef struct packed {
      logic             kind;
      logic [2:0]       status;
      logic [7:0]       data;
      logic [LEN_W-1:0] plen;
      logic             last;
   } result_t;

   typedef struct {
      frame_t     f;
      bit         typed;     // status typed in by hand
      logic [2:0] st;
   } row_t;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [7:0]       req_dst_addr;
   logic [7:0]       req_src_addr;
   logic [7:0]       req_dev_type;
   logic [7:0]       req_frame_seq;
   logic [3:0]       req_frame_len;
   logic [63:0]      req_payload;
   logic             rsp_strobe;
   logic             rsp_kind;
   logic [2:0]       rsp_status;
   logic [7:0]       rsp_data_byte;
   logic [LEN_W-1:0] rsp_packet_length;
   logic             rsp_last;

   // predictor's copy of the session table
   bit          sess_open [SESS];
   logic [23:0] sess_key  [SESS];
   int          sess_rx   [SESS];
   int          sess_total[SESS];
   logic [7:0]  sess_buf  [SESS*MAXP];

   result_t frame_out[$];        // results of the frame just modeled
   result_t pending_results[$];  // expected, oldest first
   row_t    rows[$];
   int      errors = 0;

   can_multiframe_reassembler DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_dst_addr(req_dst_addr), .req_src_addr(req_src_addr),
      .req_dev_type(req_dev_type), .req_frame_seq(req_frame_seq),
      .req_frame_len(req_frame_len), .req_payload(req_payload),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind), .rsp_status(rsp_status),
      .rsp_data_byte(rsp_data_byte), .rsp_packet_length(rsp_packet_length),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   initial begin
      #5ms;
      $display("tb: FAIL");
      $finish;
   end

   function automatic void push_status(logic [2:0] st);
      result_t r;
      r = '{KIND_STATUS, st, 8'd0, '0, 1'b1};
      frame_out = {frame_out, r};
   endfunction

   function automatic void push_byte(logic [7:0] b, int len, bit lst);
      result_t r;
      r = '{KIND_BYTE, ST_DELIVER, b, LEN_W'(len), lst};
      frame_out = {frame_out, r};
   endfunction

   function automatic int find_session(logic [23:0] key);
      for (int s = 0; s < SESS; s++)
         if (sess_open[s] && sess_key[s] == key) return s;
      return -1;
   endfunction

   // Reassembly predictor: updates the table and fills frame_out.
   function automatic void reassemble(frame_t f);
      logic [23:0] key;
      logic [7:0]  b[8];
      int          len, hit, body, total, rx, fr;
      frame_out.delete();
      key = {f.dev, f.src, f.dst};
      for (int i = 0; i < 8; i++) b[i] = f.pl[8*i +: 8];
      if (f.len == 0) begin
         push_status(ST_EMPTY);
         return;
      end
      len = (f.len > 8) ? 8 : int'(f.len);
      hit = find_session(key);
      if (hit < 0) begin
         if (len <= 3) begin
            push_status(ST_IGNORED);
            return;
         end
         body = {b[2], b[3]};
         if (body <= 4) begin
            // short packet: the frame's own bytes go out at once
            for (int i = 0; i < len; i++) push_byte(b[i], len, i + 1 == len);
            return;
         end
         total = body + 4;
         fr = -1;
         for (int s = SESS - 1; s >= 0; s--)
            if (!sess_open[s]) fr = s;
         if (f.seq != 1 || total > MAXP || fr < 0) begin
            push_status(ST_NO_SLOT);
            return;
         end
         sess_open[fr]  = 1'b1;
         sess_key[fr]   = key;
         sess_total[fr] = total;
         sess_rx[fr]    = len;
         for (int i = 0; i < len; i++) sess_buf[fr*MAXP + i] = b[i];
         push_status(ST_STORED);
      end else begin
         rx    = sess_rx[hit];
         total = sess_total[hit];
         if (f.seq == 0 || (int'(f.seq) - 1) * 8 != rx) begin
            push_status(ST_OUT_SEQ);
            return;
         end
         if (rx + len > total) begin
            push_status(ST_OVERRUN);
            return;
         end
         for (int i = 0; i < len; i++) sess_buf[hit*MAXP + rx + i] = b[i];
         rx += len;
         sess_rx[hit] = rx;
         if (rx != total) begin
            push_status(ST_STORED);
            return;
         end
         for (int i = 0; i < total; i++)
            push_byte(sess_buf[hit*MAXP + i], total, i + 1 == total);
         sess_open[hit] = 1'b0;
      end
   endfunction

   // One frame transfer; start stays high if the caller sends again at once.
   task automatic send_frame(frame_t f, bit typed, logic [2:0] st);
      result_t r;
      req_dst_addr  <= f.dst;
      req_src_addr  <= f.src;
      req_dev_type  <= f.dev;
      req_frame_seq <= f.seq;
      req_frame_len <= f.len;
      req_payload   <= f.pl;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      reassemble(f);
      if (typed) begin
         r = '{KIND_STATUS, st, 8'd0, '0, 1'b1};
         pending_results = {pending_results, r};
      end else begin
         foreach (frame_out[i]) pending_results = {pending_results, frame_out[i]};
      end
   endtask

   function automatic logic [63:0] head_payload(int body);
      logic [63:0] pl;
      pl = {$urandom, $urandom};
      pl[23:16] = body[15:8];
      pl[31:24] = body[7:0];
      return pl;
   endfunction

   function automatic frame_t mk(logic [7:0] dst, logic [7:0] src, logic [7:0] dev,
                                 logic [7:0] seq, logic [3:0] len, logic [63:0] pl);
      frame_t f;
      f = '{dst, src, dev, seq, len, pl};
      return f;
   endfunction

   function automatic void add_row(frame_t f, bit typed, logic [2:0] st);
      row_t r;
      r = '{f, typed, st};
      rows = {rows, r};
   endfunction

   // Random frame: mostly well-formed sessions on a small key pool, some broken
   // continuations, and some noise with every field random.
   function automatic frame_t random_frame();
      frame_t f;
      int     k, s, rem, body, pick;
      f = mk(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
             {$urandom, $urandom});
      if ($urandom_range(0, 99) < 18) return f;
      k = $urandom_range(0, 7);
      f.dst = 8'(k);
      f.src = 8'h5A;
      f.dev = 8'hC3;
      s = find_session({f.dev, f.src, f.dst});
      if (s >= 0) begin
         rem   = sess_total[s] - sess_rx[s];
         f.seq = 8'(sess_rx[s] / 8 + 1);
         f.len = 4'((rem > 8) ? 8 : rem);
         pick  = $urandom_range(0, 99);
         if (pick < 6) f.seq = f.seq + 8'($urandom_range(1, 2));
         else if (pick < 12 && rem < 8) f.len = 4'($urandom_range(rem + 1, 8));
      end else begin
         f.seq = 8'd1;
         f.len = 4'($urandom_range(4, 8));
         pick  = $urandom_range(0, 99);
         if (pick < 8) body = $urandom_range(0, 4);
         else if (pick < 14) body = $urandom_range(5, 60);
         else body = $urandom_range(5, 20);
         f.pl = head_payload(body);
      end
      return f;
   endfunction

   // Result checker: the receiver cannot stall, so a strobe is a transfer.
   always @(posedge clock) begin
      result_t exp_r;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d status %0d", rsp_kind, rsp_status);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_kind !== exp_r.kind) begin
               $error("kind: expected %0d, got %0d", exp_r.kind, rsp_kind);
               errors++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
               errors++;
            end
            if (rsp_data_byte !== exp_r.data) begin
               $error("data_byte: expected %0h, got %0h", exp_r.data, rsp_data_byte);
               errors++;
            end
            if (rsp_packet_length !== exp_r.plen) begin
               $error("packet_length: expected %0d, got %0d", exp_r.plen,
                      rsp_packet_length);
               errors++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last: expected %0d, got %0d", exp_r.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      frame_t f;
      int     total_frames, n;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_dst_addr  <= '0;
      req_src_addr  <= '0;
      req_dev_type  <= '0;
      req_frame_seq <= '0;
      req_frame_len <= '0;
      req_payload   <= '0;
      for (int s = 0; s < SESS; s++) sess_open[s] = 1'b0;

      // directed frames
      add_row(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, '1), 1, ST_EMPTY);
      add_row(mk(8'h00, 8'h00, 8'h00, 8'd1, 4'd3, 64'h0000_0000_0A00_0000), 1, ST_IGNORED);
      // length field above eight, short packet of eight bytes
      add_row(mk(8'h11, 8'h22, 8'h33, 8'd0, 4'd15, 64'h8877_6655_0400_2211), 0, ST_STORED);
      add_row(mk(8'h01, 8'h02, 8'h03, 8'd2, 4'd8, head_payload(10)), 1, ST_NO_SLOT);
      add_row(mk(8'h01, 8'h02, 8'h03, 8'd1, 4'd8, head_payload(61)), 1, ST_NO_SLOT);
      // largest packet: 64 bytes in eight frames, two misordered frames between
      add_row(mk(8'hA0, 8'h0A, 8'hAA, 8'd1, 4'd8, head_payload(60)), 1, ST_STORED);
      add_row(mk(8'hA0, 8'h0A, 8'hAA, 8'd3, 4'd8, {$urandom, $urandom}), 1, ST_OUT_SEQ);
      add_row(mk(8'hA0, 8'h0A, 8'hAA, 8'd0, 4'd8, {$urandom, $urandom}), 1, ST_OUT_SEQ);
      for (int q = 2; q <= 8; q++)
         add_row(mk(8'hA0, 8'h0A, 8'hAA, 8'(q), 4'd8, {$urandom, $urandom}), 0, ST_STORED);
      // overrun on a ten-byte packet, then the right tail completes it
      add_row(mk(8'hB0, 8'h0B, 8'hBB, 8'd1, 4'd8, head_payload(6)), 1, ST_STORED);
      add_row(mk(8'hB0, 8'h0B, 8'hBB, 8'd2, 4'd8, {$urandom, $urandom}), 1, ST_OVERRUN);
      add_row(mk(8'hB0, 8'h0B, 8'hBB, 8'd2, 4'd2, {$urandom, $urandom}), 0, ST_STORED);
      // fill the table with pool keys, then one more head finds no slot
      for (int k = 0; k < SESS; k++)
         add_row(mk(8'(k), 8'h5A, 8'hC3, 8'd1, 4'd8, head_payload(20)), 1, ST_STORED);
      add_row(mk(8'hEE, 8'hEE, 8'hEE, 8'd1, 4'd8, head_payload(20)), 1, ST_NO_SLOT);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      total_frames = rows.size() + RANDOM_FRAMES;
      n = 0;
      foreach (rows[i]) begin
         send_frame(rows[i].f, rows[i].typed, rows[i].st);
         n++;
         if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      repeat (RANDOM_FRAMES) begin
         f = random_frame();
         send_frame(f, 0, ST_STORED);
         n++;
         if (n < total_frames - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
